/* design/bcq_pkg.sv */
// bcq_pkg: types, widths, register codes and stage counts shared by the
// base consensus quality block; depends on nothing
package bcq_pkg;

  localparam int COUNT_BITS = 32;                  // width of one extension count
  localparam int SUM_BITS   = COUNT_BITS + 2;      // sum of three counts
  localparam int GAIN_BITS  = 12;                  // ratio factor, q8.4
  localparam int FRAC_BITS  = 4;
  localparam int PEN_BITS   = 8;
  localparam int QUAL_BITS  = 7;
  localparam int QUO_BITS   = 8;                   // ratio quotient bits before saturation
  localparam int NUM_BITS   = SUM_BITS + GAIN_BITS;
  localparam int REM_BITS   = COUNT_BITS + FRAC_BITS;
  localparam int RND_BITS   = REM_BITS + 7;        // room for 125 * remainder
  localparam int NUM_BASES  = 4;

  // round up when the fraction reaches 0.501, i.e. 125 * rem >= 1002 * d0
  localparam int RND_NUM = 125;
  localparam int RND_DEN = 1002;

  localparam int FRONT_STAGES = 4;
  localparam int DIV_STAGES   = QUO_BITS + 3;
  localparam int SEL_STAGES   = 3;
  localparam int SIDE_STAGES  = FRONT_STAGES + DIV_STAGES;
  localparam int PIPE_STAGES  = SIDE_STAGES + SEL_STAGES;

  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [NUM_BITS-1:0]    num_t;
  typedef logic [RND_BITS-1:0]    rnd_t;
  typedef logic [PEN_BITS-1:0]    pen_t;
  typedef logic [QUAL_BITS-1:0]   qual_t;
  typedef logic [QUO_BITS-1:0]    quo_t;
  typedef logic [GAIN_BITS-1:0]   gain_t;
  typedef logic [1:0]             base_idx_t;
  typedef logic [2:0]             read_code_t;
  typedef logic [PIPE_STAGES-1:0] pipe_t;

  localparam int CFG_DATA_BITS = GAIN_BITS;

  typedef enum logic [1:0] {
    CFG_DEPTH_CAP     = 2'd0,
    CFG_DIFF_GAIN     = 2'd1,
    CFG_PENALTY_CAP   = 2'd2,
    CFG_RATIO_GAIN_Q4 = 2'd3
  } cfg_idx_t;

  localparam read_code_t READ_A = 3'd1;
  localparam read_code_t READ_T = 3'd4;

  localparam base_idx_t BASE_A = 2'd0;
  localparam base_idx_t BASE_C = 2'd1;
  localparam base_idx_t BASE_G = 2'd2;
  localparam base_idx_t BASE_T = 2'd3;

  typedef struct packed {
    pen_t  depth_cap;
    pen_t  diff_gain;
    pen_t  penalty_cap;
    gain_t ratio_gain_q4;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    depth_cap:     8'd7,
    diff_gain:     8'd13,
    penalty_cap:   8'd60,
    ratio_gain_q4: 12'd160
  };

  // one base on its way from the front end into the ratio divider
  typedef struct packed {
    num_t   num;       // ratio_gain_q4 * d1
    count_t d0;
    pen_t   diff_pen;  // difference term, already clamped
    logic   dom;       // d0 >= d1: penalty is zero
    logic   zero;      // d0 == 0: ratio term is the cap
  } lane_t;

  // per-item information that rides alongside the arithmetic
  typedef struct packed {
    logic      in_range;
    logic      rev;
    logic      rb_known;
    base_idx_t rb_idx;
    qual_t     qual;
  } side_t;

endpackage

/* design/bcq_if.sv */
// bcq_if: valid/ready channels of the base consensus quality block
// (input items, results, register writes); depends on bcq_pkg
interface bcq_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcq_pkg::COUNT_BITS-1:0] count_a;
  logic [bcq_pkg::COUNT_BITS-1:0] count_c;
  logic [bcq_pkg::COUNT_BITS-1:0] count_g;
  logic [bcq_pkg::COUNT_BITS-1:0] count_t;
  logic [2:0]                  read_base;
  logic [6:0]                  read_qual;
  logic                        from_reverse;
  logic                        in_range;

  modport source (output valid, count_a, count_c, count_g, count_t, read_base, read_qual,
                  from_reverse, in_range, input ready);
  modport sink   (input valid, count_a, count_c, count_g, count_t, read_base, read_qual,
                  from_reverse, in_range, output ready);
endinterface

interface bcq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] consensus_base;
  logic [7:0] consensus_qual;
  logic [7:0] read_penalty;

  modport source (output valid, consensus_base, consensus_qual, read_penalty, input ready);
  modport sink   (input valid, consensus_base, consensus_qual, read_penalty, output ready);
endinterface

interface bcq_cfg_if;
  logic                              valid;
  logic                              ready;
  bcq_pkg::cfg_idx_t                 index;
  logic [bcq_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/bcq_front.sv */
// bcq_front: four-stage front end, competing depths, ratio numerators and
// the clamped difference term for all four bases; depends on bcq_pkg
module bcq_front (
  input  logic                                  clk,
  input  logic [bcq_pkg::FRONT_STAGES-1:0]      en,
  input  bcq_pkg::count_t                       cnt_i  [bcq_pkg::NUM_BASES],
  input  bcq_pkg::cfg_t                         cfg_i,
  output bcq_pkg::lane_t                        lane_o [bcq_pkg::NUM_BASES]
);

  bcq_pkg::count_t cnt0_r [bcq_pkg::NUM_BASES];
  bcq_pkg::sum_t   s01_r;
  bcq_pkg::sum_t   s23_r;
  bcq_pkg::count_t d0_1_r [bcq_pkg::NUM_BASES];
  bcq_pkg::sum_t   d1_r   [bcq_pkg::NUM_BASES];
  bcq_pkg::num_t   num2_r [bcq_pkg::NUM_BASES];
  bcq_pkg::count_t d0_2_r [bcq_pkg::NUM_BASES];
  logic            dom2_r [bcq_pkg::NUM_BASES];
  logic            zero2_r[bcq_pkg::NUM_BASES];
  bcq_pkg::pen_t   dif2_r [bcq_pkg::NUM_BASES];
  bcq_pkg::lane_t  lane_r [bcq_pkg::NUM_BASES];

  // pair sums
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s01_r <= bcq_pkg::sum_t'(cnt_i[bcq_pkg::BASE_A]) + bcq_pkg::sum_t'(cnt_i[bcq_pkg::BASE_C]);
      s23_r <= bcq_pkg::sum_t'(cnt_i[bcq_pkg::BASE_G]) + bcq_pkg::sum_t'(cnt_i[bcq_pkg::BASE_T]);
    end
  end

  for (genvar c = 0; c < bcq_pkg::NUM_BASES; c++) begin : g_lane
    // the other pair plus the partner in this pair
    localparam int PARTNER = c ^ 1;

    bcq_pkg::pen_t t_cap;
    logic          dpos;
    logic [2*bcq_pkg::PEN_BITS-1:0] prod;
    logic [2*bcq_pkg::PEN_BITS-1:0] prod_lo;
    bcq_pkg::pen_t diff_pen;

    always_ff @(posedge clk) begin
      if (en[0]) begin
        cnt0_r[c] <= cnt_i[c];
      end
      if (en[1]) begin
        d0_1_r[c] <= cnt0_r[c];
        d1_r[c]   <= ((c < 2) ? s23_r : s01_r) + bcq_pkg::sum_t'(cnt0_r[PARTNER]);
      end
    end

    always_comb begin
      t_cap = (d1_r[c] < bcq_pkg::sum_t'(cfg_i.depth_cap))
            ? d1_r[c][bcq_pkg::PEN_BITS-1:0] : cfg_i.depth_cap;
      dpos  = bcq_pkg::count_t'(t_cap) > d0_1_r[c];
    end

    always_ff @(posedge clk) begin
      if (en[2]) begin
        num2_r[c]  <= bcq_pkg::num_t'(cfg_i.ratio_gain_q4) * bcq_pkg::num_t'(d1_r[c]);
        d0_2_r[c]  <= d0_1_r[c];
        dom2_r[c]  <= bcq_pkg::sum_t'(d0_1_r[c]) >= d1_r[c];
        zero2_r[c] <= d0_1_r[c] == '0;
        dif2_r[c]  <= dpos ? t_cap - d0_1_r[c][bcq_pkg::PEN_BITS-1:0] : '0;
      end
    end

    // difference term, raised to one and lowered to the cap
    always_comb begin
      prod     = (2*bcq_pkg::PEN_BITS)'(dif2_r[c]) * (2*bcq_pkg::PEN_BITS)'(cfg_i.diff_gain);
      prod_lo  = (prod == '0) ? (2*bcq_pkg::PEN_BITS)'(1) : prod;
      diff_pen = (prod_lo > (2*bcq_pkg::PEN_BITS)'(cfg_i.penalty_cap))
               ? cfg_i.penalty_cap : prod_lo[bcq_pkg::PEN_BITS-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[3]) begin
        lane_r[c] <= '{num: num2_r[c], d0: d0_2_r[c], diff_pen: diff_pen,
                       dom: dom2_r[c], zero: zero2_r[c]};
      end
    end

    assign lane_o[c] = lane_r[c];
  end

endmodule

/* design/bcq_div.sv */
// bcq_div: pipelined ratio term for one base, restoring division one
// quotient bit per stage, then rounding and the final per-base penalty; depends on bcq_pkg
module bcq_div (
  input  logic                            clk,
  input  logic [bcq_pkg::DIV_STAGES-1:0]  en,
  input  bcq_pkg::lane_t                  lane_i,
  input  bcq_pkg::pen_t                   cap_i,
  output bcq_pkg::pen_t                   pen_o
);

  localparam int STEPS = bcq_pkg::QUO_BITS;
  localparam int RND   = STEPS + 1;
  localparam int FIN   = STEPS + 2;

  bcq_pkg::num_t   rem_r  [0:STEPS];
  bcq_pkg::quo_t   quo_r  [0:STEPS];
  bcq_pkg::count_t d0_r   [0:STEPS];
  bcq_pkg::pen_t   dp_r   [0:RND];
  logic            dom_r  [0:RND];
  logic            zero_r [0:RND];
  logic            sat_r  [0:RND];
  bcq_pkg::quo_t   quo_rnd_r;
  bcq_pkg::rnd_t   lhs_r;
  bcq_pkg::rnd_t   rhs_r;
  bcq_pkg::pen_t   pen_r;

  bcq_pkg::num_t   sat_lim;
  logic            up;
  bcq_pkg::pen_t   ratio;
  bcq_pkg::pen_t   ratio_pen;
  bcq_pkg::pen_t   pen_nxt;

  // quotient of 256 or more saturates
  assign sat_lim = bcq_pkg::num_t'(lane_i.d0) << (bcq_pkg::QUO_BITS + bcq_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= lane_i.num;
      quo_r[0]  <= '0;
      d0_r[0]   <= lane_i.d0;
      dp_r[0]   <= lane_i.diff_pen;
      dom_r[0]  <= lane_i.dom;
      zero_r[0] <= lane_i.zero;
      sat_r[0]  <= lane_i.num >= sat_lim;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    localparam int SH = STEPS - k + bcq_pkg::FRAC_BITS;

    bcq_pkg::num_t trial;
    logic          fit;

    assign trial = bcq_pkg::num_t'(d0_r[k-1]) << SH;
    assign fit   = rem_r[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= fit ? rem_r[k-1] - trial : rem_r[k-1];
        quo_r[k]  <= {quo_r[k-1][bcq_pkg::QUO_BITS-2:0], fit};
        d0_r[k]   <= d0_r[k-1];
        dp_r[k]   <= dp_r[k-1];
        dom_r[k]  <= dom_r[k-1];
        zero_r[k] <= zero_r[k-1];
        sat_r[k]  <= sat_r[k-1];
      end
    end
  end

  // both sides of the rounding compare
  always_ff @(posedge clk) begin
    if (en[RND]) begin
      lhs_r       <= bcq_pkg::rnd_t'(bcq_pkg::RND_NUM) * bcq_pkg::rnd_t'(rem_r[STEPS]);
      rhs_r       <= bcq_pkg::rnd_t'(bcq_pkg::RND_DEN) * bcq_pkg::rnd_t'(d0_r[STEPS]);
      quo_rnd_r   <= quo_r[STEPS];
      dp_r[RND]   <= dp_r[STEPS];
      dom_r[RND]  <= dom_r[STEPS];
      zero_r[RND] <= zero_r[STEPS];
      sat_r[RND]  <= sat_r[STEPS];
    end
  end

  always_comb begin
    up        = lhs_r >= rhs_r;
    ratio     = (sat_r[RND] || (up && quo_rnd_r == '1))
              ? '1 : quo_rnd_r + bcq_pkg::quo_t'(up);
    ratio_pen = zero_r[RND] ? cap_i : ratio;
    pen_nxt   = dom_r[RND] ? '0 : ((dp_r[RND] < ratio_pen) ? dp_r[RND] : ratio_pen);
  end

  always_ff @(posedge clk) begin
    if (en[FIN]) begin
      pen_r <= pen_nxt;
    end
  end

  assign pen_o = pen_r;

endmodule

/* design/bcq_select.sv */
// bcq_select: adds the read quality, finds lowest and second-lowest penalty
// and forms the result fields over three stages; depends on bcq_pkg
module bcq_select (
  input  logic                            clk,
  input  logic [bcq_pkg::SEL_STAGES-1:0]  en,
  input  bcq_pkg::pen_t                   pen_i [bcq_pkg::NUM_BASES],
  input  bcq_pkg::side_t                  side_i,
  input  bcq_pkg::pen_t                   cap_i,
  output bcq_pkg::base_idx_t              cons_base_o,
  output bcq_pkg::pen_t                   cons_qual_o,
  output bcq_pkg::pen_t                   read_pen_o
);

  bcq_pkg::pen_t      q_r [bcq_pkg::NUM_BASES];
  bcq_pkg::side_t     side0_r;
  bcq_pkg::side_t     side1_r;
  bcq_pkg::pen_t      mn_r;
  bcq_pkg::pen_t      mn2_r;
  bcq_pkg::base_idx_t mnc_r;
  bcq_pkg::pen_t      rbq_r;
  bcq_pkg::base_idx_t base_r;
  bcq_pkg::pen_t      qual_r;
  bcq_pkg::pen_t      rpen_r;

  for (genvar c = 0; c < bcq_pkg::NUM_BASES; c++) begin : g_add
    logic is_read;
    assign is_read = side_i.rb_known && (side_i.rb_idx == bcq_pkg::base_idx_t'(c));
    always_ff @(posedge clk) begin
      if (en[0]) begin
        q_r[c] <= pen_i[c] + (is_read ? '0 : bcq_pkg::pen_t'(side_i.qual));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side0_r <= side_i;
    end
  end

  // pairwise tree, lower index wins a tie
  logic               lt01, lt23, win23;
  bcq_pkg::pen_t      lo01, hi01, lo23, hi23;
  bcq_pkg::base_idx_t i01, i23;
  bcq_pkg::pen_t      mn, mn2;
  bcq_pkg::base_idx_t mnc;

  always_comb begin
    lt01  = q_r[bcq_pkg::BASE_C] < q_r[bcq_pkg::BASE_A];
    lt23  = q_r[bcq_pkg::BASE_T] < q_r[bcq_pkg::BASE_G];
    lo01  = lt01 ? q_r[bcq_pkg::BASE_C] : q_r[bcq_pkg::BASE_A];
    hi01  = lt01 ? q_r[bcq_pkg::BASE_A] : q_r[bcq_pkg::BASE_C];
    i01   = lt01 ? bcq_pkg::BASE_C : bcq_pkg::BASE_A;
    lo23  = lt23 ? q_r[bcq_pkg::BASE_T] : q_r[bcq_pkg::BASE_G];
    hi23  = lt23 ? q_r[bcq_pkg::BASE_G] : q_r[bcq_pkg::BASE_T];
    i23   = lt23 ? bcq_pkg::BASE_T : bcq_pkg::BASE_G;
    win23 = lo23 < lo01;
    mn    = win23 ? lo23 : lo01;
    mnc   = win23 ? i23 : i01;
    if (win23) begin
      mn2 = (hi23 < lo01) ? hi23 : lo01;
    end else begin
      mn2 = (hi01 < lo23) ? hi01 : lo23;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mn_r    <= mn;
      mn2_r   <= mn2;
      mnc_r   <= mnc;
      rbq_r   <= q_r[side0_r.rb_idx];
      side1_r <= side0_r;
    end
  end

  bcq_pkg::pen_t      gap, rgap;
  bcq_pkg::pen_t      qual_nxt, rpen_nxt;
  bcq_pkg::base_idx_t base_nxt;

  always_comb begin
    gap      = mn2_r - mn_r;
    rgap     = side1_r.rb_known ? rbq_r - mn_r : '0;
    qual_nxt = (gap > cap_i) ? cap_i : gap;
    rpen_nxt = (rgap > cap_i) ? cap_i : rgap;
    base_nxt = side1_r.rev ? ~mnc_r : mnc_r;
    if (!side1_r.in_range) begin
      qual_nxt = '0;
      rpen_nxt = '0;
      base_nxt = bcq_pkg::BASE_A;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      base_r <= base_nxt;
      qual_r <= qual_nxt;
      rpen_r <= rpen_nxt;
    end
  end

  assign cons_base_o = base_r;
  assign cons_qual_o = qual_r;
  assign read_pen_o  = rpen_r;

endmodule

/* design/base_consensus_quality.sv */
// base_consensus_quality: top level, register file, pipeline valid and
// enable chain, per-item side line; depends on bcq_pkg, bcq_if, bcq_front, bcq_div, bcq_select
//
// Per read position this block takes the four extension counts with the read base
// and quality, and returns the consensus base, its quality and the read base's
// excess penalty. It is an 18-stage pipeline that takes one transaction every clock
// while not full and stalled on the output: four front-end stages (depth sums, the
// ratio numerator multiply, the difference term), eleven stages per base of ratio
// division (a saturation check, eight restoring steps producing one quotient bit
// each, and two rounding stages), and three selection stages. Each stage holds its
// contents while the stage after it is full and stalled, so empty stages keep
// filling while a finished result waits on the output. Registers are written
// through the configuration channel, always ready, and must only be written when
// no transaction is in flight.
module base_consensus_quality (
  input  logic      clk,
  input  logic      rst_n,
  bcq_in_if.sink    in_ch,
  bcq_out_if.source out_ch,
  bcq_cfg_if.sink   cfg_ch
);

  // stage layout along the pipeline
  localparam int DIV_BASE = bcq_pkg::FRONT_STAGES;
  localparam int SEL_BASE = bcq_pkg::SIDE_STAGES;

  bcq_pkg::cfg_t  cfg_r;
  bcq_pkg::pipe_t v_r;
  bcq_pkg::pipe_t v_nxt;
  bcq_pkg::pipe_t en;
  bcq_pkg::side_t side_r [bcq_pkg::SIDE_STAGES];
  bcq_pkg::side_t side_in;

  bcq_pkg::count_t cnt  [bcq_pkg::NUM_BASES];
  bcq_pkg::lane_t  lane [bcq_pkg::NUM_BASES];
  bcq_pkg::pen_t   pen  [bcq_pkg::NUM_BASES];

  bcq_pkg::base_idx_t rb_raw;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bcq_pkg::CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bcq_pkg::CFG_DEPTH_CAP:     cfg_r.depth_cap     <= cfg_ch.data[bcq_pkg::PEN_BITS-1:0];
        bcq_pkg::CFG_DIFF_GAIN:     cfg_r.diff_gain     <= cfg_ch.data[bcq_pkg::PEN_BITS-1:0];
        bcq_pkg::CFG_PENALTY_CAP:   cfg_r.penalty_cap   <= cfg_ch.data[bcq_pkg::PEN_BITS-1:0];
        bcq_pkg::CFG_RATIO_GAIN_Q4: cfg_r.ratio_gain_q4 <= cfg_ch.data[bcq_pkg::GAIN_BITS-1:0];
      endcase
    end
  end

  // a stage may load when the output drains or some stage at or after it is empty
  always_comb begin
    for (int k = 0; k < bcq_pkg::PIPE_STAGES; k++) begin
      en[k] = out_ch.ready || ~&(v_r | bcq_pkg::pipe_t'((1 << k) - 1));
    end
  end

  assign in_ch.ready = en[0];
  assign v_nxt = (en & {v_r[bcq_pkg::PIPE_STAGES-2:0], in_ch.valid}) | (~en & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // read base: codes other than A..T count as N; reverse strand complements
  assign rb_raw = bcq_pkg::base_idx_t'(in_ch.read_base - bcq_pkg::READ_A);

  always_comb begin
    side_in.in_range = in_ch.in_range;
    side_in.rev      = in_ch.from_reverse;
    side_in.rb_known = (in_ch.read_base >= bcq_pkg::READ_A) &&
                       (in_ch.read_base <= bcq_pkg::READ_T);
    side_in.rb_idx   = in_ch.from_reverse ? ~rb_raw : rb_raw;
    side_in.qual     = in_ch.read_qual;
  end

  // side line travels in step with the arithmetic up to the select stages
  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k < bcq_pkg::SIDE_STAGES; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign cnt[bcq_pkg::BASE_A] = in_ch.count_a;
  assign cnt[bcq_pkg::BASE_C] = in_ch.count_c;
  assign cnt[bcq_pkg::BASE_G] = in_ch.count_g;
  assign cnt[bcq_pkg::BASE_T] = in_ch.count_t;

  bcq_front u_front (
    .clk    (clk),
    .en     (en[bcq_pkg::FRONT_STAGES-1:0]),
    .cnt_i  (cnt),
    .cfg_i  (cfg_r),
    .lane_o (lane)
  );

  // one ratio divider per base, running side by side
  for (genvar c = 0; c < bcq_pkg::NUM_BASES; c++) begin : g_div
    bcq_div u_div (
      .clk    (clk),
      .en     (en[DIV_BASE +: bcq_pkg::DIV_STAGES]),
      .lane_i (lane[c]),
      .cap_i  (cfg_r.penalty_cap),
      .pen_o  (pen[c])
    );
  end

  bcq_select u_select (
    .clk         (clk),
    .en          (en[SEL_BASE +: bcq_pkg::SEL_STAGES]),
    .pen_i       (pen),
    .side_i      (side_r[bcq_pkg::SIDE_STAGES-1]),
    .cap_i       (cfg_r.penalty_cap),
    .cons_base_o (out_ch.consensus_base),
    .cons_qual_o (out_ch.consensus_qual),
    .read_pen_o  (out_ch.read_penalty)
  );

  // last stage is the output register
  assign out_ch.valid = v_r[bcq_pkg::PIPE_STAGES-1];

endmodule
